@@ sv/dfa_pkg.sv @@
// ----------------------------------------------------------------------------
// D8 flow accumulation package
// Word formats, operation and status codes, register indexes and the D8
// step tables shared by the flow accumulation unit.
// ----------------------------------------------------------------------------
`default_nettype none

package dfa_pkg;

    // Field widths of the input and result words.
    localparam int IDX_W    = 16;
    localparam int DIR_W    = 8;
    localparam int WEIGHT_W = 32;
    localparam int VALUE_W  = 48;

    // Accumulation memory depth, one entry per linear cell index.
    localparam int STORE_DEPTH = 65536;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_DIM_W  = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLUMNS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNIT_WEIGHTS = 2'd2;

    localparam logic [CFG_DIM_W-1:0] GRID_ROWS_RESET    = 9'd256;
    localparam logic [CFG_DIM_W-1:0] GRID_COLUMNS_RESET = 9'd256;

    // 1.0 in Q32.16 and the saturation ceiling.
    localparam logic [VALUE_W-1:0] ONE_Q16   = 48'h0000_0001_0000;
    localparam logic [VALUE_W-1:0] VALUE_MAX = 48'hFFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_ROUTE  = 2'd1,
        OP_READ   = 2'd2,
        OP_UNUSED = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK           = 2'd0,
        STATUS_CELL_OUTSIDE = 2'd1,
        STATUS_NBR_OUTSIDE  = 2'd2,
        STATUS_RESERVED     = 2'd3
    } status_t;

    // Offset of one grid coordinate when stepping to a D8 neighbor.
    typedef enum logic [1:0] {
        STEP_ZERO  = 2'd0,
        STEP_PLUS  = 2'd1,
        STEP_MINUS = 2'd2
    } step_t;

    // Row and column steps, indexed by the highest set direction bit.
    localparam step_t ROW_STEP [8] = '{
        STEP_ZERO, STEP_PLUS, STEP_PLUS, STEP_PLUS,
        STEP_ZERO, STEP_MINUS, STEP_MINUS, STEP_MINUS
    };
    localparam step_t COL_STEP [8] = '{
        STEP_PLUS, STEP_PLUS, STEP_ZERO, STEP_MINUS,
        STEP_MINUS, STEP_MINUS, STEP_ZERO, STEP_PLUS
    };

    typedef struct packed {
        op_t                 op;
        logic [IDX_W-1:0]    cell_index;
        logic [DIR_W-1:0]    direction;
        logic [WEIGHT_W-1:0] weight;
    } item_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        status_t            status;
    } result_t;

endpackage

`default_nettype wire

@@ sv/dfa_ram.sv @@
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dfa_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data valid in the cycle after the address.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ sv/d8_flow_accumulation_unit.sv @@
// ----------------------------------------------------------------------------
// D8 flow accumulation unit
// Keeps one Q32.16 accumulation per raster cell and applies load, route and
// read words to it, one word at a time.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; its result word shows
// on result for exactly one cycle with done high and must be captured then.
// Every word first splits its cell index into row and column with a shared
// restoring divider that makes one quotient bit per cycle. A load, a sink
// route, an unused op or a rejected word then ends in the evaluation state.
// A read adds one accumulation memory read, and a route reads the source and
// the target through the single read port before it writes the sum. The
// memory is not cleared at reset; cells must be loaded before they are read
// or routed.
// ----------------------------------------------------------------------------
`default_nettype none

module d8_flow_accumulation_unit
    import dfa_pkg::*;
#(
    parameter int MAX_ROWS    = 256,
    parameter int MAX_COLUMNS = 256
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire item_t                 item,
    output logic                       busy,
    output logic                       done,
    output result_t                    result,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int ROW_W = $clog2(MAX_ROWS + 1);
    localparam int COL_W = $clog2(MAX_COLUMNS + 1);
    localparam int RCW   = (CFG_DIM_W > ROW_W) ? CFG_DIM_W : ROW_W;
    localparam int CCW   = (CFG_DIM_W > COL_W) ? CFG_DIM_W : COL_W;
    localparam int CNT_W = $clog2(IDX_W);
    localparam int T_W   = IDX_W + 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_EVAL,
        ST_READ_OUT,
        ST_FETCH_SRC,
        ST_FETCH_DST
    } state_t;

    // Configuration registers.
    logic [CFG_DIM_W-1:0] grid_rows_reg;
    logic [CFG_DIM_W-1:0] grid_columns_reg;
    logic                 unit_weights_reg;

    // Control and registered outputs.
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             done_reg, done_next;
    result_t          result_reg, result_next;

    // Word payload and divider datapath.
    item_t              item_reg, item_next;
    logic [IDX_W-1:0]   quot_reg, quot_next;
    logic [ROW_W-1:0]   rem_reg, rem_next;
    logic [VALUE_W-1:0] src_reg, src_next;
    logic [IDX_W-1:0]   target_reg, target_next;

    // Effective grid size after clamping.
    logic [RCW-1:0]   rows_wide;
    logic [CCW-1:0]   cols_wide;
    logic [ROW_W-1:0] rows_eff;
    logic [COL_W-1:0] cols_eff;

    // Divider step.
    logic [ROW_W:0] div_trial;
    logic [ROW_W:0] div_diff;
    logic           div_ge;

    // Neighbor evaluation.
    logic [2:0]     dir_code;
    step_t          row_step;
    step_t          col_step;
    logic           cell_outside;
    logic           row_off;
    logic           col_off;
    logic           tgt_off;
    logic [ROW_W:0] row_inc;
    logic [IDX_W:0] col_inc;
    logic [T_W-1:0] col_term;
    logic [T_W-1:0] row_term;
    logic [T_W-1:0] target_wide;
    logic [VALUE_W:0] sum_wide;

    // Memory ports.
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [VALUE_W-1:0] ram_wdata;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [VALUE_W-1:0] ram_rdata;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg    <= GRID_ROWS_RESET;
            grid_columns_reg <= GRID_COLUMNS_RESET;
            unit_weights_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GRID_ROWS:    grid_rows_reg    <= cfg_data[CFG_DIM_W-1:0];
                CFG_GRID_COLUMNS: grid_columns_reg <= cfg_data[CFG_DIM_W-1:0];
                CFG_UNIT_WEIGHTS: unit_weights_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // Clamp the grid size: zero acts as one, large values as the maximum.
    always_comb
    begin
        rows_wide = RCW'(grid_rows_reg);
        cols_wide = CCW'(grid_columns_reg);
        if (rows_wide == RCW'(0))
        begin
            rows_wide = RCW'(1);
        end
        else if (rows_wide > RCW'(MAX_ROWS))
        begin
            rows_wide = RCW'(MAX_ROWS);
        end
        if (cols_wide == CCW'(0))
        begin
            cols_wide = CCW'(1);
        end
        else if (cols_wide > CCW'(MAX_COLUMNS))
        begin
            cols_wide = CCW'(MAX_COLUMNS);
        end
        rows_eff = ROW_W'(rows_wide);
        cols_eff = COL_W'(cols_wide);
    end

    // One restoring division step: shift in the next dividend bit and
    // subtract the row count when it fits.
    assign div_trial = {rem_reg, quot_reg[IDX_W-1]};
    assign div_diff  = div_trial - {1'b0, rows_eff};
    assign div_ge    = (div_trial >= {1'b0, rows_eff});

    // Highest set direction bit selects the neighbor.
    always_comb
    begin
        dir_code = 3'd0;
        for (int i = 0; i < DIR_W; i++)
        begin
            if (item_reg.direction[i])
            begin
                dir_code = 3'(i);
            end
        end
    end

    assign row_step = ROW_STEP[dir_code];
    assign col_step = COL_STEP[dir_code];

    // Grid checks on the quotient (column) and remainder (row).
    assign cell_outside = ({1'b0, quot_reg} >= (IDX_W + 1)'(cols_eff));
    assign row_inc      = (ROW_W + 1)'(rem_reg) + (ROW_W + 1)'(1);
    assign col_inc      = (IDX_W + 1)'(quot_reg) + (IDX_W + 1)'(1);

    assign row_off = ((row_step == STEP_MINUS) && (rem_reg == ROW_W'(0)))
                  || ((row_step == STEP_PLUS) && (row_inc >= (ROW_W + 1)'(rows_eff)));
    assign col_off = ((col_step == STEP_MINUS) && (quot_reg == IDX_W'(0)))
                  || ((col_step == STEP_PLUS) && (col_inc >= (IDX_W + 1)'(cols_eff)));

    // Neighbor index as an offset from the source index.
    always_comb
    begin
        case (col_step)
            STEP_PLUS:  col_term = T_W'(rows_eff);
            STEP_MINUS: col_term = T_W'(0) - T_W'(rows_eff);
            default:    col_term = T_W'(0);
        endcase
        case (row_step)
            STEP_PLUS:  row_term = T_W'(1);
            STEP_MINUS: row_term = T_W'(0) - T_W'(1);
            default:    row_term = T_W'(0);
        endcase
    end

    assign target_wide = T_W'(item_reg.cell_index) + col_term + row_term;
    assign tgt_off     = |target_wide[T_W-1:IDX_W];

    // Saturating accumulation of source into target.
    assign sum_wide = {1'b0, ram_rdata} + {1'b0, src_reg};

    // Sequencer.
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        result_next = '{value: '0, status: STATUS_OK};
        item_next   = item_reg;
        quot_next   = quot_reg;
        rem_next    = rem_reg;
        src_next    = src_reg;
        target_next = target_reg;
        ram_we      = 1'b0;
        ram_waddr   = item_reg.cell_index;
        ram_wdata   = ONE_Q16;
        ram_re      = 1'b0;
        ram_raddr   = item_reg.cell_index;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    item_next  = item;
                    quot_next  = item.cell_index;
                    rem_next   = '0;
                    count_next = '0;
                    state_next = ST_DIVIDE;
                end
            end

            ST_DIVIDE:
            begin
                rem_next   = div_ge ? div_diff[ROW_W-1:0] : div_trial[ROW_W-1:0];
                quot_next  = {quot_reg[IDX_W-2:0], div_ge};
                count_next = count_reg + CNT_W'(1);
                if (count_reg == CNT_W'(IDX_W - 1))
                begin
                    state_next = ST_EVAL;
                end
            end

            ST_EVAL:
            begin
                state_next = ST_IDLE;
                done_next  = 1'b1;
                if (item_reg.op == OP_UNUSED)
                begin
                    result_next.status = STATUS_OK;
                end
                else if (cell_outside)
                begin
                    result_next.status = STATUS_CELL_OUTSIDE;
                end
                else
                begin
                    unique case (item_reg.op)
                        OP_LOAD:
                        begin
                            ram_we    = 1'b1;
                            ram_wdata = unit_weights_reg ? ONE_Q16
                                                         : VALUE_W'(item_reg.weight);
                        end
                        OP_READ:
                        begin
                            ram_re     = 1'b1;
                            done_next  = 1'b0;
                            state_next = ST_READ_OUT;
                        end
                        OP_ROUTE:
                        begin
                            if (item_reg.direction == '0)
                            begin
                                result_next.status = STATUS_OK;
                            end
                            else if (row_off || col_off || tgt_off)
                            begin
                                result_next.status = STATUS_NBR_OUTSIDE;
                            end
                            else
                            begin
                                ram_re      = 1'b1;
                                target_next = target_wide[IDX_W-1:0];
                                done_next   = 1'b0;
                                state_next  = ST_FETCH_SRC;
                            end
                        end
                        default:
                        begin
                            result_next.status = STATUS_OK;
                        end
                    endcase
                end
            end

            ST_READ_OUT:
            begin
                result_next.value = ram_rdata;
                done_next         = 1'b1;
                state_next        = ST_IDLE;
            end

            ST_FETCH_SRC:
            begin
                src_next   = ram_rdata;
                ram_re     = 1'b1;
                ram_raddr  = target_reg;
                state_next = ST_FETCH_DST;
            end

            ST_FETCH_DST:
            begin
                ram_we     = 1'b1;
                ram_waddr  = target_reg;
                ram_wdata  = sum_wide[VALUE_W] ? VALUE_MAX : sum_wide[VALUE_W-1:0];
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            done_reg   <= 1'b0;
            result_reg <= '{value: '0, status: STATUS_OK};
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            done_reg   <= done_next;
            result_reg <= result_next;
        end
    end

    // Payload and divider registers.
    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        quot_reg   <= quot_next;
        rem_reg    <= rem_next;
        src_reg    <= src_next;
        target_reg <= target_next;
    end

    // Accumulation memory.
    dfa_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire
